[rtl/core/plbf_pkg.sv]
// shared types and constants for the panel lamp brightness framer
package plbf_pkg;

    localparam int unsigned ACC_W       = 16;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned PAIRS       = 8;
    localparam int unsigned CELLS       = 3 * PAIRS;
    localparam int unsigned LAMP_BITS   = 2 * CELLS;

    localparam logic [ACC_W-1:0]  LAMP_HIGH_INC = 16'h0400;
    localparam logic [ACC_W-1:0]  LAMP_LOW_INC  = 16'h0004;
    localparam logic [WORD_W-1:0] FULL_HIGH     = 16'h6400;
    localparam logic [WORD_W-1:0] FULL_LOW      = 16'd100;
    localparam logic [15:0]       INT_IO_MASK   = 16'h000c;
    localparam logic [15:0]       INT_TASK_MASK = 16'h0001;

    // frame word positions
    localparam logic [IDX_W-1:0] W_PC        = 6'd0;
    localparam logic [IDX_W-1:0] W_DATA      = 6'd1;
    localparam logic [IDX_W-1:0] W_SWITCH    = 6'd2;
    localparam logic [IDX_W-1:0] W_STATUS    = 6'd3;
    localparam logic [IDX_W-1:0] W_POWER     = 6'd4;
    localparam logic [IDX_W-1:0] W_ADDR_LO   = 6'd5;
    localparam logic [IDX_W-1:0] W_DATA_HI   = 6'd20;
    localparam logic [IDX_W-1:0] W_SW_LO     = 6'd21;
    localparam logic [IDX_W-1:0] W_SW_HI     = 6'd28;
    localparam logic [IDX_W-1:0] W_STAT_LO   = 6'd29;
    localparam logic [IDX_W-1:0] W_STAT_HI   = 6'd36;
    localparam logic [IDX_W-1:0] W_PWR_LAMP  = 6'd37;
    localparam logic [IDX_W-1:0] W_RUN_LAMP  = 6'd38;
    localparam logic [IDX_W-1:0] W_LAST      = 6'd44;

    typedef struct packed {
        logic add_en;
        logic shift_en;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

endpackage

[rtl/core/plbf_cell.sv]
// one lamp pair accumulator cell of the readout chain
module plbf_cell
    import plbf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic             i_hi,
    input  logic             i_lo,
    input  logic [ACC_W-1:0] i_next,
    output logic [ACC_W-1:0] o_acc
);

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.shift_en) begin
            n_acc = i_next;
        end else if (i_ctl.add_en) begin
            n_acc = r_acc + (i_hi ? LAMP_HIGH_INC : '0) + (i_lo ? LAMP_LOW_INC : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

[rtl/core/panel_lamp_brightness_framer.sv]
// top level: lamp accumulator chain, tick counter and frame sequencer
//
// Input channel (i_in_valid / o_in_stall) takes one sample tick of machine
// state per word. Every tick adds its lamp pair on-times into a row of 24
// accumulator cells (address, data, status). A tick that is not a frame tick
// is accepted without a stall and gives no output.
// Every FRAME_TICKS-th tick starts a 45 word frame on the output channel
// (o_out_valid / i_out_stall): the first word is shown the cycle after the
// tick is taken, then one word per cycle while not stalled; o_last_word marks
// word 44. The accumulators leave through the head of the cell chain, one
// cell per emitted brightness word, and zeros enter at the tail, so the chain
// is clear when the frame ends.
// A frame tick therefore occupies the block until its last word is taken;
// o_in_stall is high for the whole frame.
// A stall on the output holds the current word and freezes the chain.
// Reset (synchronous, active low) clears the tick count and all cells and
// drops any frame in progress.
module panel_lamp_brightness_framer
    import plbf_pkg::*;
#(
    parameter int unsigned FRAME_TICKS = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [15:0]       i_program_counter,
    input  logic [15:0]       i_data_word,
    input  logic [15:0]       i_switch_word,
    input  logic [3:0]        i_condition_codes,
    input  logic              i_privileged_mode,
    input  logic              i_pipeline_mode,
    input  logic              i_virtual_mode,
    input  logic [15:0]       i_active_interrupts,
    input  logic [4:0]        i_extended_address,
    input  logic              i_power_on,
    input  logic              i_run_light,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [IDX_W-1:0]  o_word_index,
    output logic [WORD_W-1:0] o_word_value,
    output logic              o_last_word
);

    localparam int unsigned TICK_W = $clog2(FRAME_TICKS + 1);

    t_state                         r_state;
    t_state                         n_state;
    logic [TICK_W-1:0]              r_tick;
    logic [TICK_W-1:0]              n_tick;
    logic [TICK_W-1:0]              w_tick_inc;
    logic [IDX_W-1:0]               r_idx;
    logic [IDX_W-1:0]               n_idx;
    logic [15:0]                    r_pc;
    logic [15:0]                    r_data;
    logic [15:0]                    r_sw;
    logic [15:0]                    r_status;
    logic                           r_pwr;
    logic                           r_run;
    logic [15:0]                    w_status;
    logic [LAMP_BITS-1:0]           w_lamp_bits;
    logic                           w_in_acc;
    logic                           w_out_acc;
    logic                           w_chain_word;
    logic [2:0]                     w_sw_pair;
    logic [15:0]                    w_sw_shift;
    t_cell_ctl                      w_ctl;
    logic [CELLS-1:0][ACC_W-1:0]    w_acc;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;

    assign w_status = {i_condition_codes, 1'b0, i_privileged_mode, i_pipeline_mode,
                       i_virtual_mode, |(i_active_interrupts & INT_IO_MASK),
                       |(i_active_interrupts & INT_TASK_MASK), 1'b0, i_extended_address};

    assign w_lamp_bits = {i_program_counter, i_data_word, w_status};

    // brightness words that come out of the chain head
    assign w_chain_word = ((r_idx >= W_ADDR_LO) && (r_idx <= W_DATA_HI)) ||
                          ((r_idx >= W_STAT_LO) && (r_idx <= W_STAT_HI));

    assign w_ctl.add_en   = w_in_acc;
    assign w_ctl.shift_en = w_out_acc && w_chain_word;

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        logic [ACC_W-1:0] w_next;
        if (k == CELLS - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_link
            assign w_next = w_acc[k+1];
        end
        plbf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_hi    (w_lamp_bits[LAMP_BITS-1-2*k]),
            .i_lo    (w_lamp_bits[LAMP_BITS-2-2*k]),
            .i_next  (w_next),
            .o_acc   (w_acc[k])
        );
    end

    assign w_tick_inc = r_tick + 1'b1;

    always_comb begin
        n_state = r_state;
        n_tick  = r_tick;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_tick_inc == TICK_W'(FRAME_TICKS)) begin
                        n_tick  = '0;
                        n_idx   = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_tick = w_tick_inc;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_acc) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == W_LAST) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tick  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_idx   <= n_idx;
        end
    end

    // frame snapshot of the tick's raw words
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pc     <= i_program_counter;
            r_data   <= i_data_word;
            r_sw     <= i_switch_word;
            r_status <= w_status;
            r_pwr    <= i_power_on;
            r_run    <= i_run_light;
        end
    end

    assign w_sw_pair  = 3'(r_idx - W_SW_LO);
    assign w_sw_shift = r_sw << {w_sw_pair, 1'b0};

    always_comb begin
        case (r_idx) inside
            W_PC:                  o_word_value = r_pc;
            W_DATA:                o_word_value = r_data;
            W_SWITCH:              o_word_value = r_sw;
            W_STATUS:              o_word_value = r_status;
            W_POWER:               o_word_value = {r_pwr, 2'b00, r_run, 12'h000};
            [W_ADDR_LO:W_DATA_HI]: o_word_value = w_acc[0];
            [W_SW_LO:W_SW_HI]:     o_word_value = (w_sw_shift[15] ? FULL_HIGH : '0) |
                                                  (w_sw_shift[14] ? FULL_LOW : '0);
            [W_STAT_LO:W_STAT_HI]: o_word_value = w_acc[0];
            W_PWR_LAMP:            o_word_value = r_pwr ? FULL_HIGH : '0;
            W_RUN_LAMP:            o_word_value = r_run ? FULL_LOW : '0;
            default:               o_word_value = '0;
        endcase
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = (r_state == S_EMIT);
    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == W_LAST);

    a_frame_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_word_index == W_PC))
        else $error("frame did not start at word 0");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_last_word) |=> (!o_out_valid && !o_in_stall))
        else $error("frame did not end after last word");

    a_chain_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_last_word) |=> (w_acc == '0))
        else $error("accumulator chain not cleared after frame");

    a_tick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick < TICK_W'(FRAME_TICKS))
        else $error("tick count out of range");

endmodule
